FILE: hdl/kvc_pkg.sv
// ============================================================================
// kvc_pkg: shared types and codes of the key/value cache store
// Command and status codes, configuration bundle, queue and result items.
// ============================================================================
package kvc_pkg;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_WRITE = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;
    localparam cmd_t CMD_QUERY = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_LAYER    = 3'd1;
    localparam status_t ST_BATCH    = 3'd2;
    localparam status_t ST_CAPACITY = 3'd3;
    localparam status_t ST_LENGTH   = 3'd4;
    localparam status_t ST_RANGE    = 3'd5;

    // one length entry per value of the 1-bit batch field
    localparam int SLOT_COUNT = 2;

    typedef struct packed {
        logic [1:0] layer_count;
        logic [1:0] batch_capacity;
        logic [2:0] kv_head_count;
        logic [6:0] head_size;
        logic [7:0] sequence_capacity;
    } cfg_t;

    // classified request as it travels from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic        batch;
        logic        batch_ok;
        logic [6:0]  position;
        status_t     pre_status;
        logic        hd_bad;
        logic [31:0] key_word;
        logic [31:0] value_word;
    } queue_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic [7:0]  cached_length;
    } result_t;

endpackage

FILE: hdl/kvc_fifo.sv
// ============================================================================
// kvc_fifo: small synchronous queue
// Register-based ring with occupancy count; first word shown on rdata.
// ============================================================================
module kvc_fifo
    import kvc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hdl/kvc_front.sv
// ============================================================================
// kvc_front: request intake, classification and address pipeline
// Range checks at intake, then one stride multiply per stage.
// ============================================================================
module kvc_front
    import kvc_pkg::*;
#(
    parameter int MAX_LAYERS    = 2,
    parameter int MAX_BATCH     = 2,
    parameter int MAX_KV_HEADS  = 4,
    parameter int MAX_HEAD_SIZE = 64,
    parameter int MAX_SEQUENCE  = 128,
    parameter int AW            = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              push,
    output logic              full,
    input  cmd_t              cmd,
    input  logic              layer,
    input  logic              batch,
    input  logic [1:0]        head,
    input  logic [6:0]        position,
    input  logic [5:0]        dim,
    input  logic [31:0]       key_word,
    input  logic [31:0]       value_word,
    output logic              q_push,
    input  logic              q_full,
    output queue_item_t       q_item,
    output logic [AW-1:0]     q_addr
);

    localparam longint unsigned P1 = longint'(MAX_LAYERS) * longint'(MAX_BATCH);
    localparam longint unsigned P2 = P1 * longint'(MAX_KV_HEADS);
    localparam longint unsigned P3 = P2 * longint'(MAX_SEQUENCE);
    localparam int W1 = (P1 > 1) ? $clog2(P1) : 1;
    localparam int W2 = (P2 > 1) ? $clog2(P2) : 1;
    localparam int W3 = (P3 > 1) ? $clog2(P3) : 1;

    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    queue_item_t    item1_reg, item2_reg, item3_reg, item4_reg;
    logic [1:0]     head1_reg;
    logic [5:0]     dim1_reg, dim2_reg, dim3_reg;
    logic [W1-1:0]  a1_reg;
    logic [W2-1:0]  a2_reg;
    logic [W3-1:0]  a3_reg;
    logic [AW-1:0]  a4_reg;

    logic           advance, accept;
    logic           layer_ok, batch_ok;
    queue_item_t    item_in;

    // whole pipe moves together; it only holds when the last stage is blocked
    assign advance = !v4_reg || !q_full;
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = v4_reg && !q_full;
    assign q_item  = item4_reg;
    assign q_addr  = a4_reg;

    assign layer_ok = ({1'b0, layer} < cfg.layer_count);
    assign batch_ok = ({1'b0, batch} < cfg.batch_capacity);

    always_comb
    begin
        item_in.cmd        = cmd;
        item_in.batch      = batch;
        item_in.batch_ok   = batch_ok;
        item_in.position   = position;
        item_in.key_word   = key_word;
        item_in.value_word = value_word;
        item_in.hd_bad     = ({1'b0, head} >= cfg.kv_head_count) ||
                             ({1'b0, dim} >= cfg.head_size);
        item_in.pre_status = ST_OK;
        case (cmd)
            CMD_WRITE, CMD_READ:
            begin
                if (!layer_ok)
                begin
                    item_in.pre_status = ST_LAYER;
                end
                else if (!batch_ok)
                begin
                    item_in.pre_status = ST_BATCH;
                end
                else if (cmd == CMD_WRITE && {1'b0, position} >= cfg.sequence_capacity)
                begin
                    item_in.pre_status = ST_CAPACITY;
                end
            end
            default:
            begin
                if (!batch_ok)
                begin
                    item_in.pre_status = ST_BATCH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // flat offset; modular width is exact since the true offset fits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item1_reg <= item_in;
            head1_reg <= head;
            dim1_reg  <= dim;
            a1_reg    <= W1'(layer) * W1'(cfg.batch_capacity) + W1'(batch);

            item2_reg <= item1_reg;
            dim2_reg  <= dim1_reg;
            a2_reg    <= W2'(a1_reg) * W2'(cfg.kv_head_count) + W2'(head1_reg);

            item3_reg <= item2_reg;
            dim3_reg  <= dim2_reg;
            a3_reg    <= W3'(a2_reg) * W3'(cfg.sequence_capacity) + W3'(item2_reg.position);

            item4_reg <= item3_reg;
            a4_reg    <= AW'(a3_reg) * AW'(cfg.head_size) + AW'(dim3_reg);
        end
    end

endmodule

FILE: hdl/kvc_back.sv
// ============================================================================
// kvc_back: request execution
// Slot length table, key/value memories and result generation.
// ============================================================================
module kvc_back
    import kvc_pkg::*;
#(
    parameter int              AW    = 17,
    parameter longint unsigned DEPTH = 131072
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear_lengths,
    input  logic          q_empty,
    input  queue_item_t   q_item,
    input  logic [AW-1:0] q_addr,
    output logic          q_pop,
    input  logic          out_full,
    output logic          out_push,
    output result_t       out_result
);

    typedef enum logic [1:0] {
        B_RUN  = 2'b01,
        B_READ = 2'b10
    } back_state_t;

    back_state_t  state_reg, state_next;
    logic [7:0]   len_reg [SLOT_COUNT];
    logic [7:0]   pend_len_reg;
    logic [31:0]  key_rd_reg, value_rd_reg;
    logic [31:0]  key_mem   [DEPTH];
    logic [31:0]  value_mem [DEPTH];

    logic         issue, mem_we, mem_re, len_we;
    logic [7:0]   slot_len, len_wdata, out_len, pos_inc;
    status_t      status;

    assign issue    = (state_reg == B_RUN) && !q_empty && !out_full;
    assign q_pop    = issue;
    assign slot_len = q_item.batch_ok ? len_reg[q_item.batch] : 8'd0;
    assign pos_inc  = {1'b0, q_item.position} + 8'd1;

    always_comb
    begin
        status    = q_item.pre_status;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        len_we    = 1'b0;
        len_wdata = slot_len;
        out_len   = slot_len;
        if (issue)
        begin
            case (q_item.cmd)
                CMD_WRITE:
                begin
                    if (q_item.pre_status == ST_OK)
                    begin
                        if (q_item.hd_bad)
                        begin
                            status = ST_RANGE;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (pos_inc > slot_len)
                            begin
                                len_we    = 1'b1;
                                len_wdata = pos_inc;
                                out_len   = pos_inc;
                            end
                        end
                    end
                end
                CMD_READ:
                begin
                    if (q_item.pre_status == ST_OK)
                    begin
                        if ({1'b0, q_item.position} >= slot_len)
                        begin
                            status = ST_LENGTH;
                        end
                        else if (q_item.hd_bad)
                        begin
                            status = ST_RANGE;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    if (q_item.batch_ok)
                    begin
                        len_we    = 1'b1;
                        len_wdata = 8'd0;
                        out_len   = 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_RUN:
            begin
                if (mem_re)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:  state_next = B_RUN;
            default: state_next = B_RUN;
        endcase
    end

    // a read result goes out in the cycle after issue, when memory data lands
    always_comb
    begin
        if (state_reg == B_READ)
        begin
            out_push   = 1'b1;
            out_result = '{status: ST_OK, key_out: key_rd_reg,
                           value_out: value_rd_reg, cached_length: pend_len_reg};
        end
        else
        begin
            out_push   = issue && !mem_re;
            out_result = '{status: status, key_out: 32'd0,
                           value_out: 32'd0, cached_length: out_len};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_RUN;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                len_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clear_lengths)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    len_reg[i] <= 8'd0;
                end
            end
            else if (len_we)
            begin
                len_reg[q_item.batch] <= len_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            pend_len_reg <= slot_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[q_addr]   <= q_item.key_word;
            value_mem[q_addr] <= q_item.value_word;
        end
        if (mem_re)
        begin
            key_rd_reg   <= key_mem[q_addr];
            value_rd_reg <= value_mem[q_addr];
        end
    end

endmodule

FILE: hdl/kv_cache_store_top.sv
// ============================================================================
// kv_cache_store_top: key/value cache for attention inference
// Configuration registers, front/back split with queues between them.
// ============================================================================
//  Requests: drive the fields with push high; a request is taken at a clock
//  edge where push is high and full is low. cmd selects write element, read
//  element, clear slot or query length.
//  Results: while empty is low the oldest result sits on status/key_out/
//  value_out/cached_length; pop high takes it.
//  Configuration: cfg_write with cfg_index 0..4 (layer count, batch capacity,
//  head count, head size, sequence capacity). Only the field's low bits count;
//  zero is ignored, larger values saturate to the instance maximum. Capacity
//  writes zero all slot lengths. Write only while no request is outstanding.
//  A write, clear or query result passes the front stages, middle queue and
//  result queue; a read result also waits on registered memory data. Front
//  takes a request per cycle while full is low; back does write/clear/query
//  at one per cycle if queues allow; a read stalls issue till its data is out.
//  Reset clears lengths, queues and config to defaults; memory is not reset.
//  A stalled pop fills the output queue, then middle queue and pipe; full rises.
// ============================================================================
module kv_cache_store_top
    import kvc_pkg::*;
#(
    parameter int MAX_LAYERS    = 2,
    parameter int MAX_BATCH     = 2,
    parameter int MAX_KV_HEADS  = 4,
    parameter int MAX_HEAD_SIZE = 64,
    parameter int MAX_SEQUENCE  = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic        layer,
    input  logic        batch,
    input  logic [1:0]  head,
    input  logic [6:0]  position,
    input  logic [5:0]  dim,
    input  logic [31:0] key_word,
    input  logic [31:0] value_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] key_out,
    output logic [31:0] value_out,
    output logic [7:0]  cached_length
);

    localparam longint unsigned DEPTH = longint'(MAX_LAYERS) * longint'(MAX_BATCH) *
                                        longint'(MAX_KV_HEADS) * longint'(MAX_SEQUENCE) *
                                        longint'(MAX_HEAD_SIZE);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = AW + $bits(queue_item_t);
    localparam int RW = $bits(result_t);

    localparam logic [2:0] REG_LAYERS   = 3'd0;
    localparam logic [2:0] REG_BATCH    = 3'd1;
    localparam logic [2:0] REG_HEADS    = 3'd2;
    localparam logic [2:0] REG_HEAD_SZ  = 3'd3;
    localparam logic [2:0] REG_SEQ      = 3'd4;

    localparam logic [1:0] RST_LAYERS  = 2'((MAX_LAYERS < 2) ? MAX_LAYERS : 2);
    localparam logic [1:0] RST_BATCH   = 2'((MAX_BATCH < 2) ? MAX_BATCH : 2);
    localparam logic [2:0] RST_HEADS   = 3'((MAX_KV_HEADS < 4) ? MAX_KV_HEADS : 4);
    localparam logic [6:0] RST_HEAD_SZ = 7'((MAX_HEAD_SIZE < 64) ? MAX_HEAD_SIZE : 64);
    localparam logic [7:0] RST_SEQ     = 8'((MAX_SEQUENCE < 128) ? MAX_SEQUENCE : 128);

    cfg_t           cfg_reg;
    logic           clear_lengths;

    logic           fq_push, fq_full, fq_empty, fq_pop;
    queue_item_t    front_item, back_item;
    logic [AW-1:0]  front_addr, back_addr;
    logic [QW-1:0]  fq_rdata;

    logic           oq_push, oq_full;
    result_t        back_result, oq_result;
    logic [RW-1:0]  oq_rdata;

    // ---- configuration registers: zero ignored, oversize saturates ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layer_count       <= RST_LAYERS;
            cfg_reg.batch_capacity    <= RST_BATCH;
            cfg_reg.kv_head_count     <= RST_HEADS;
            cfg_reg.head_size         <= RST_HEAD_SZ;
            cfg_reg.sequence_capacity <= RST_SEQ;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LAYERS:
                begin
                    if (cfg_data[1:0] != 2'd0)
                    begin
                        cfg_reg.layer_count <= (32'(cfg_data[1:0]) > 32'(MAX_LAYERS)) ?
                                               2'(MAX_LAYERS) : cfg_data[1:0];
                    end
                end
                REG_BATCH:
                begin
                    if (cfg_data[1:0] != 2'd0)
                    begin
                        cfg_reg.batch_capacity <= (32'(cfg_data[1:0]) > 32'(MAX_BATCH)) ?
                                                  2'(MAX_BATCH) : cfg_data[1:0];
                    end
                end
                REG_HEADS:
                begin
                    if (cfg_data[2:0] != 3'd0)
                    begin
                        cfg_reg.kv_head_count <= (32'(cfg_data[2:0]) > 32'(MAX_KV_HEADS)) ?
                                                 3'(MAX_KV_HEADS) : cfg_data[2:0];
                    end
                end
                REG_HEAD_SZ:
                begin
                    if (cfg_data[6:0] != 7'd0)
                    begin
                        cfg_reg.head_size <= (32'(cfg_data[6:0]) > 32'(MAX_HEAD_SIZE)) ?
                                             7'(MAX_HEAD_SIZE) : cfg_data[6:0];
                    end
                end
                REG_SEQ:
                begin
                    if (cfg_data != 8'd0)
                    begin
                        cfg_reg.sequence_capacity <= (32'(cfg_data) > 32'(MAX_SEQUENCE)) ?
                                                     8'(MAX_SEQUENCE) : cfg_data;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // capacity change invalidates every cached length
    assign clear_lengths = cfg_write &&
                           (((cfg_index == REG_BATCH) && (cfg_data[1:0] != 2'd0)) ||
                            ((cfg_index == REG_SEQ) && (cfg_data != 8'd0)));

    // ---- front: intake, checks, address pipe ----
    kvc_front #(
        .MAX_LAYERS    (MAX_LAYERS),
        .MAX_BATCH     (MAX_BATCH),
        .MAX_KV_HEADS  (MAX_KV_HEADS),
        .MAX_HEAD_SIZE (MAX_HEAD_SIZE),
        .MAX_SEQUENCE  (MAX_SEQUENCE),
        .AW            (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .layer      (layer),
        .batch      (batch),
        .head       (head),
        .position   (position),
        .dim        (dim),
        .key_word   (key_word),
        .value_word (value_word),
        .q_push     (fq_push),
        .q_full     (fq_full),
        .q_item     (front_item),
        .q_addr     (front_addr)
    );

    // ---- decoupling queue between front and back ----
    kvc_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata ({front_addr, front_item}),
        .full  (fq_full),
        .pop   (fq_pop),
        .rdata (fq_rdata),
        .empty (fq_empty)
    );

    assign back_addr = fq_rdata[QW-1 -: AW];
    assign back_item = queue_item_t'(fq_rdata[$bits(queue_item_t)-1:0]);

    // ---- back: lengths, memories, results ----
    kvc_back #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear_lengths (clear_lengths),
        .q_empty       (fq_empty),
        .q_item        (back_item),
        .q_addr        (back_addr),
        .q_pop         (fq_pop),
        .out_full      (oq_full),
        .out_push      (oq_push),
        .out_result    (back_result)
    );

    // ---- result queue: back keeps working while the receiver stalls, until it fills ----
    kvc_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (back_result),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign oq_result     = result_t'(oq_rdata);
    assign status        = oq_result.status;
    assign key_out       = oq_result.key_out;
    assign value_out     = oq_result.value_out;
    assign cached_length = oq_result.cached_length;

endmodule
